### rtl/ima_pkg.sv
package ima_pkg;

    // Field widths of the stream and configuration beats
    localparam int IDX_W   = 3;
    localparam int DIM_W   = 4;
    localparam int VALUE_W = 32;

    // Index width carried down the cell chain (covers the largest array size)
    localparam int TOK_IDX_W = 6;

    // Opcodes on s_axis_tuser
    localparam logic [1:0] OP_LOAD_A = 2'd0;
    localparam logic [1:0] OP_LOAD_B = 2'd1;
    localparam logic [1:0] OP_MULT   = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_ROWS_A = 2'd0;
    localparam logic [1:0] REG_COLS_A = 2'd1;
    localparam logic [1:0] REG_ROWS_B = 2'd2;
    localparam logic [1:0] REG_COLS_B = 2'd3;

    // Element load broadcast to every cell
    typedef struct packed {
        logic               we_a;
        logic               we_b;
        logic [IDX_W-1:0]   row;
        logic [IDX_W-1:0]   col;
        logic [VALUE_W-1:0] value;
    } wr_t;

    // Work token handed from cell to cell: one product element
    typedef struct packed {
        logic                 valid;
        logic                 last;
        logic [TOK_IDX_W-1:0] row;
        logic [TOK_IDX_W-1:0] col;
    } tok_t;

endpackage

### rtl/ima_ram.sv
module ima_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/ima_cell.sv
module ima_cell #(
    parameter int MAX_DIM = 8,
    parameter int K       = 0
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        adv,
    input  logic                        active,
    input  ima_pkg::wr_t                wr,
    input  ima_pkg::tok_t               tok_in,
    output ima_pkg::tok_t               tok_out,
    input  logic [ima_pkg::VALUE_W-1:0] sum_in,
    output logic [ima_pkg::VALUE_W-1:0] sum_out
);

    localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

    ima_pkg::tok_t               tok_reg;
    logic [ima_pkg::VALUE_W-1:0] a_rd;
    logic [ima_pkg::VALUE_W-1:0] b_rd;
    logic [ima_pkg::VALUE_W-1:0] prod_reg;
    logic [ima_pkg::VALUE_W-1:0] sum_reg;
    logic                        we_a;
    logic                        we_b;

    // This cell keeps column K of A and row K of B
    assign we_a = wr.we_a && (32'(wr.col) == 32'(K));
    assign we_b = wr.we_b && (32'(wr.row) == 32'(K));

    ima_ram #(
        .WIDTH (ima_pkg::VALUE_W),
        .DEPTH (MAX_DIM)
    ) u_col_a (
        .clk   (clk),
        .we    (we_a),
        .waddr (AW'(wr.row)),
        .wdata (wr.value),
        .re    (adv),
        .raddr (AW'(tok_in.row)),
        .rdata (a_rd)
    );

    ima_ram #(
        .WIDTH (ima_pkg::VALUE_W),
        .DEPTH (MAX_DIM)
    ) u_row_b (
        .clk   (clk),
        .we    (we_b),
        .waddr (AW'(wr.col)),
        .wdata (wr.value),
        .re    (adv),
        .raddr (AW'(tok_in.col)),
        .rdata (b_rd)
    );

    // Token is registered here before it moves on to the next cell; it holds while adv is low
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else if (adv)
        begin
            tok_reg <= tok_in;
        end
    end

    // Multiply, then add onto the partial sum arriving from the left
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg <= active ? a_rd * b_rd : '0;
            sum_reg  <= sum_in + prod_reg;
        end
    end

    assign tok_out = tok_reg;
    assign sum_out = sum_reg;

endmodule

### rtl/integer_matrix_multiply.sv
// Integer matrix multiplier C = A x B, signed 32-bit, sums wrap modulo 2^32.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): rows_a, cols_a,
// rows_b, cols_b, index 0..3, always ready; write only while idle.
// Input stream: tuser carries the opcode (load A, load B, multiply); a load
// beat writes one element at (row, col) and produces no output. Loads are
// taken one per cycle while the block is idle.
// A multiply beat checks cols_a against rows_b. On a mismatch one beat comes
// out with tuser (not possible) and tlast set. Otherwise the product comes
// out in row-major order, one beat per cycle unless the output stalls, tlast on the final element.
// Each column k of A / row k of B lives in cell k of a chain of MAX_DIM
// cells; a token per output element walks the chain, each cell adding one
// term. A token passes the issue register, the cells and the alignment
// registers tok_d1/tok_d2 before its sum reaches the output register. The
// input is not ready during a run.
// A stall on m_axis_tready freezes the whole chain; nothing is lost.
// Reset sets all four dimensions to 1 and empties the chain; the element
// stores are not cleared and must be loaded before use.
module integer_matrix_multiply #(
    parameter int MAX_DIM = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [3:0]  cfg_data,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // row[2:0], col[5:3], value[37:6], zero pad
    input  logic [1:0]  s_axis_tuser,   // op[1:0]
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // out_row[2:0], out_col[5:3], product[37:6], zero pad
    output logic        m_axis_tuser,   // not_possible[0]
    output logic        m_axis_tlast
);

    localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DW = $clog2(MAX_DIM + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_NP,
        ST_DRAIN
    } state_t;

    state_t state_reg;

    logic [ima_pkg::DIM_W-1:0] rows_a_reg;
    logic [ima_pkg::DIM_W-1:0] cols_a_reg;
    logic [ima_pkg::DIM_W-1:0] rows_b_reg;
    logic [ima_pkg::DIM_W-1:0] cols_b_reg;

    logic [DW-1:0] ra;
    logic [DW-1:0] ca;
    logic [DW-1:0] rb;
    logic [DW-1:0] cb;

    logic [IW-1:0] i_reg;
    logic [IW-1:0] j_reg;
    logic          row_end;
    logic          col_end;

    ima_pkg::tok_t tok_issue_reg;
    ima_pkg::tok_t tok_d1_reg;
    ima_pkg::tok_t tok_d2_reg;

    logic                           out_valid_reg;
    logic [ima_pkg::IDX_W-1:0]      out_row_reg;
    logic [ima_pkg::IDX_W-1:0]      out_col_reg;
    logic [ima_pkg::VALUE_W-1:0]    product_reg;
    logic                           np_reg;
    logic                           last_reg;

    logic                           adv;
    logic                           s_acc;
    logic [1:0]                     in_op;
    logic [ima_pkg::IDX_W-1:0]      in_row;
    logic [ima_pkg::IDX_W-1:0]      in_col;
    logic                           in_range;
    ima_pkg::wr_t                   wr;

    ima_pkg::tok_t               tok_chain [MAX_DIM+1];
    logic [ima_pkg::VALUE_W-1:0] sum_chain [MAX_DIM+1];
    logic [MAX_DIM-1:0]          cell_on;

    // Clamp a dimension register into 1..MAX_DIM
    function automatic logic [DW-1:0] eff_dim(input logic [ima_pkg::DIM_W-1:0] v);
        if (v == '0)
            return DW'(1);
        else if (32'(v) > 32'(MAX_DIM))
            return DW'(MAX_DIM);
        else
            return DW'(v);
    endfunction

    assign ra = eff_dim(rows_a_reg);
    assign ca = eff_dim(cols_a_reg);
    assign rb = eff_dim(rows_b_reg);
    assign cb = eff_dim(cols_b_reg);

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_a_reg <= ima_pkg::DIM_W'(1);
            cols_a_reg <= ima_pkg::DIM_W'(1);
            rows_b_reg <= ima_pkg::DIM_W'(1);
            cols_b_reg <= ima_pkg::DIM_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                ima_pkg::REG_ROWS_A: rows_a_reg <= cfg_data;
                ima_pkg::REG_COLS_A: cols_a_reg <= cfg_data;
                ima_pkg::REG_ROWS_B: rows_b_reg <= cfg_data;
                ima_pkg::REG_COLS_B: cols_b_reg <= cfg_data;
                default:             rows_a_reg <= rows_a_reg;
            endcase
        end
    end

    // Input beat decode and element load broadcast
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign in_op         = s_axis_tuser;
    assign in_row        = s_axis_tdata[2:0];
    assign in_col        = s_axis_tdata[5:3];
    assign in_range      = (32'(in_row) < 32'(MAX_DIM)) && (32'(in_col) < 32'(MAX_DIM));

    assign wr.we_a  = s_acc && in_range && (in_op == ima_pkg::OP_LOAD_A);
    assign wr.we_b  = s_acc && in_range && (in_op == ima_pkg::OP_LOAD_B);
    assign wr.row   = in_row;
    assign wr.col   = in_col;
    assign wr.value = s_axis_tdata[37:6];

    // Whole chain moves when the output register is free or being emptied
    assign adv = !out_valid_reg || m_axis_tready;

    assign row_end = (DW'(i_reg) + DW'(1)) == ra;
    assign col_end = (DW'(j_reg) + DW'(1)) == cb;

    // Cell chain: cell k adds A[i][k] * B[k][j]
    assign tok_chain[0] = tok_issue_reg;
    assign sum_chain[0] = '0;

    for (genvar k = 0; k < MAX_DIM; k++)
    begin : g_cell
        assign cell_on[k] = 32'(ca) > 32'(k);

        ima_cell #(
            .MAX_DIM (MAX_DIM),
            .K       (k)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (adv),
            .active  (cell_on[k]),
            .wr      (wr),
            .tok_in  (tok_chain[k]),
            .tok_out (tok_chain[k+1]),
            .sum_in  (sum_chain[k]),
            .sum_out (sum_chain[k+1])
        );
    end

    // Sequencer, token issue, alignment delay and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            i_reg         <= '0;
            j_reg         <= '0;
            tok_issue_reg <= '0;
            tok_d1_reg    <= '0;
            tok_d2_reg    <= '0;
            out_valid_reg <= 1'b0;
            out_row_reg   <= '0;
            out_col_reg   <= '0;
            product_reg   <= '0;
            np_reg        <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_acc && (in_op == ima_pkg::OP_MULT))
                    begin
                        i_reg     <= '0;
                        j_reg     <= '0;
                        state_reg <= (ca != rb) ? ST_NP : ST_RUN;
                    end
                end
                ST_RUN:
                begin
                    if (adv)
                    begin
                        if (col_end)
                        begin
                            j_reg <= '0;
                            i_reg <= i_reg + IW'(1);
                        end
                        else
                        begin
                            j_reg <= j_reg + IW'(1);
                        end
                        if (row_end && col_end)
                        begin
                            state_reg <= ST_DRAIN;
                        end
                    end
                end
                ST_NP:
                begin
                    if (adv)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_DRAIN:
                begin
                    if (adv && tok_d2_reg.valid && tok_d2_reg.last)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase

            if (adv)
            begin
                // next token into the chain
                tok_issue_reg.valid <= (state_reg == ST_RUN);
                tok_issue_reg.last  <= row_end && col_end;
                tok_issue_reg.row   <= ima_pkg::TOK_IDX_W'(i_reg);
                tok_issue_reg.col   <= ima_pkg::TOK_IDX_W'(j_reg);

                // line the token up with the sum leaving the last cell
                tok_d1_reg <= tok_chain[MAX_DIM];
                tok_d2_reg <= tok_d1_reg;

                if (state_reg == ST_NP)
                begin
                    out_valid_reg <= 1'b1;
                    out_row_reg   <= '0;
                    out_col_reg   <= '0;
                    product_reg   <= '0;
                    np_reg        <= 1'b1;
                    last_reg      <= 1'b1;
                end
                else
                begin
                    out_valid_reg <= tok_d2_reg.valid;
                    out_row_reg   <= tok_d2_reg.row[ima_pkg::IDX_W-1:0];
                    out_col_reg   <= tok_d2_reg.col[ima_pkg::IDX_W-1:0];
                    product_reg   <= sum_chain[MAX_DIM];
                    np_reg        <= 1'b0;
                    last_reg      <= tok_d2_reg.last;
                end
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, product_reg, out_col_reg, out_row_reg};
    assign m_axis_tuser  = np_reg;
    assign m_axis_tlast  = last_reg;

endmodule

### verif/integer_matrix_multiply_tb.sv
`timescale 1ns / 100ps

module integer_matrix_multiply_tb;

    localparam int MAX_DIM = 8;
    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [1:0] OP_NONE = 2'd3;
    localparam int SETTLE_CYCLES = 3 * (MAX_DIM + 4);
    localparam int HOLD_CYCLES = 300;
    localparam int ITEM_TARGET = 330;
    localparam int MAX_PRINTED = 40;

    typedef struct packed {
        logic [1:0]  op;
        logic [2:0]  row;
        logic [2:0]  col;
        logic [31:0] value;
    } elem_req_t;

    typedef struct packed {
        logic [2:0]  row;
        logic [2:0]  col;
        logic [31:0] product;
        logic        not_possible;
        logic        last;
    } prod_beat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [3:0]  cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    // predictor state: element stores and dimension registers as last written
    logic [31:0] elem_a [DEPTH];
    logic [31:0] elem_b [DEPTH];
    logic [3:0]  dim_rows_a = 4'd1;
    logic [3:0]  dim_cols_a = 4'd1;
    logic [3:0]  dim_rows_b = 4'd1;
    logic [3:0]  dim_cols_b = 4'd1;

    // stimulus bookkeeping: which store entries the queued items have loaded
    bit          loaded_a [DEPTH];
    bit          loaded_b [DEPTH];
    elem_req_t   req_q[$];
    prod_beat_t  product_q[$];
    elem_req_t   on_bus;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_left = 0;
    bit hold_arm = 1'b0;
    bit hold_taken = 1'b0;

    int err_count = 0;
    int queued = 0;
    int items_in = 0;
    int beats_out = 0;
    int mult_runs = 0;
    int no_product_runs = 0;
    int phase_count = 0;

    integer_matrix_multiply #(.MAX_DIM(MAX_DIM)) dut (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [ADDR_W-1:0] addr_of(int r, int c);
        return ADDR_W'(r * MAX_DIM + c);
    endfunction

    // zero counts as 1, anything above MAX_DIM counts as MAX_DIM
    function automatic int eff_dim(logic [3:0] v);
        if (v == 4'd0)
            return 1;
        if (v > MAX_DIM)
            return MAX_DIM;
        return int'(v);
    endfunction

    // update the stores, or work out every beat of a multiply run
    task automatic predict_products(elem_req_t it);
        int ra;
        int ca;
        int rb;
        int cb;
        logic [31:0] acc;
        prod_beat_t pb;
        ra = eff_dim(dim_rows_a);
        ca = eff_dim(dim_cols_a);
        rb = eff_dim(dim_rows_b);
        cb = eff_dim(dim_cols_b);
        case (it.op)
            ima_pkg::OP_LOAD_A: elem_a[addr_of(int'(it.row), int'(it.col))] = it.value;
            ima_pkg::OP_LOAD_B: elem_b[addr_of(int'(it.row), int'(it.col))] = it.value;
            ima_pkg::OP_MULT:
            begin
                mult_runs++;
                if (ca != rb)
                begin
                    no_product_runs++;
                    pb = '{row: 3'd0, col: 3'd0, product: 32'd0, not_possible: 1'b1, last: 1'b1};
                    product_q.push_back(pb);
                end
                else
                begin
                    for (int i = 0; i < ra; i++)
                    begin
                        for (int j = 0; j < cb; j++)
                        begin
                            acc = '0;
                            for (int k = 0; k < ca; k++)
                                acc += elem_a[addr_of(i, k)] * elem_b[addr_of(k, j)];
                            pb.row = 3'(i);
                            pb.col = 3'(j);
                            pb.product = acc;
                            pb.not_possible = 1'b0;
                            pb.last = (i == ra - 1) && (j == cb - 1);
                            product_q.push_back(pb);
                        end
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        err_count++;
        if (err_count <= MAX_PRINTED)
            $display("ERROR %0t: %s got %0h want %0h", $time, what, got, want);
    endtask

    task automatic check_beat();
        prod_beat_t got;
        prod_beat_t want;
        got.row = m_axis_tdata[2:0];
        got.col = m_axis_tdata[5:3];
        got.product = m_axis_tdata[37:6];
        got.not_possible = m_axis_tuser;
        got.last = m_axis_tlast;
        beats_out++;
        if (product_q.size() == 0)
        begin
            report_mismatch("result beat with nothing expected, product", got.product, 32'd0);
            return;
        end
        want = product_q.pop_front();
        if (got.row != want.row)
            report_mismatch("out_row", 32'(got.row), 32'(want.row));
        if (got.col != want.col)
            report_mismatch("out_col", 32'(got.col), 32'(want.col));
        if (got.product != want.product)
            report_mismatch("product", got.product, want.product);
        if (got.not_possible != want.not_possible)
            report_mismatch("not_possible", 32'(got.not_possible), 32'(want.not_possible));
        if (got.last != want.last)
            report_mismatch("last", 32'(got.last), 32'(want.last));
    endtask

    // input driver: predicts on each accepted beat, then offers the next one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_products(on_bus);
                items_in++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (req_q.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    on_bus = req_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {2'b00, on_bus.value, on_bus.col, on_bus.row};
                    s_axis_tuser <= on_bus.op;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                check_beat();
            m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // long receiver hold-off, armed once
    always @(posedge clk)
    begin
        if (hold_arm && !hold_taken)
        begin
            hold_left <= HOLD_CYCLES;
            hold_taken <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    task automatic cfg_write(logic [1:0] idx, logic [3:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        case (idx)
            ima_pkg::REG_ROWS_A: dim_rows_a = data;
            ima_pkg::REG_COLS_A: dim_cols_a = data;
            ima_pkg::REG_ROWS_B: dim_rows_b = data;
            ima_pkg::REG_COLS_B: dim_cols_b = data;
            default: ;
        endcase
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(3))
            0: return 32'($urandom_range(200)) - 32'd100;
            1:
            begin
                case ($urandom_range(3))
                    0: return 32'h8000_0000;
                    1: return 32'h7fff_ffff;
                    2: return 32'hffff_ffff;
                    default: return 32'd0;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [3:0] pick_dim();
        case ($urandom_range(9))
            0: return 4'd0;
            1: return 4'($urandom_range(15, 9));
            default: return 4'($urandom_range(4, 1));
        endcase
    endfunction

    task automatic queue_item(logic [1:0] op, int r, int c, logic [31:0] v);
        elem_req_t it;
        it.op = op;
        it.row = 3'(r);
        it.col = 3'(c);
        it.value = v;
        if (op == ima_pkg::OP_LOAD_A)
            loaded_a[addr_of(r, c)] = 1'b1;
        if (op == ima_pkg::OP_LOAD_B)
            loaded_b[addr_of(r, c)] = 1'b1;
        req_q.push_back(it);
        queued++;
    endtask

    // a multiply may only read entries that some load has already written
    function automatic bit mult_is_safe();
        int ca;
        ca = eff_dim(dim_cols_a);
        if (ca != eff_dim(dim_rows_b))
            return 1'b1;
        for (int i = 0; i < eff_dim(dim_rows_a); i++)
            for (int k = 0; k < ca; k++)
                if (!loaded_a[addr_of(i, k)])
                    return 1'b0;
        for (int k = 0; k < ca; k++)
            for (int j = 0; j < eff_dim(dim_cols_b); j++)
                if (!loaded_b[addr_of(k, j)])
                    return 1'b0;
        return 1'b1;
    endfunction

    task automatic queue_noise();
        logic [1:0] op;
        op = 2'($urandom_range(3));
        if (op == ima_pkg::OP_MULT && !mult_is_safe())
            op = OP_NONE;
        queue_item(op, $urandom_range(7), $urandom_range(7), pick_value());
    endtask

    // load every operand the current shape lacks (and reload some others with fresh values), then multiply
    task automatic queue_product_run();
        for (int i = 0; i < eff_dim(dim_rows_a); i++)
            for (int k = 0; k < eff_dim(dim_cols_a); k++)
                if (!loaded_a[addr_of(i, k)] || $urandom_range(1))
                    queue_item(ima_pkg::OP_LOAD_A, i, k, pick_value());
        for (int k = 0; k < eff_dim(dim_rows_b); k++)
            for (int j = 0; j < eff_dim(dim_cols_b); j++)
                if (!loaded_b[addr_of(k, j)] || $urandom_range(1))
                    queue_item(ima_pkg::OP_LOAD_B, k, j, pick_value());
        queue_item(ima_pkg::OP_MULT, $urandom_range(7), $urandom_range(7), $urandom);
    endtask

    // block is quiet: nothing queued, nothing offered, nothing outstanding
    task automatic wait_idle();
        do
            @(negedge clk);
        while (req_q.size() != 0 || s_axis_tvalid || product_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic run_phase(logic [3:0] ra, logic [3:0] ca, logic [3:0] rb, logic [3:0] cb,
                             int mode, int runs, bit long_hold);
        wait_idle();
        cfg_write(ima_pkg::REG_ROWS_A, ra);
        cfg_write(ima_pkg::REG_COLS_A, ca);
        cfg_write(ima_pkg::REG_ROWS_B, rb);
        cfg_write(ima_pkg::REG_COLS_B, cb);
        @(negedge clk);
        phase_count++;
        send_idle_pct = (mode == 1) ? 77 : (mode == 3) ? 14 : 0;
        recv_stall_pct = (mode == 2) ? 77 : (mode == 3) ? 14 : 0;
        if (long_hold)
            hold_arm = 1'b1;
        for (int n = 0; n < runs; n++)
        begin
            repeat ($urandom_range(2)) queue_noise();
            queue_product_run();
            if (queued >= ITEM_TARGET)
                break;
        end
    endtask

    initial
    begin
        int phase_no;
        logic [3:0] ra;
        logic [3:0] ca;
        logic [3:0] rb;
        logic [3:0] cb;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: 1x1 shape after reset, value extremes, unused opcode
        queue_item(OP_NONE, 7, 7, 32'hffff_ffff);
        queue_item(ima_pkg::OP_LOAD_A, 0, 0, 32'h7fff_ffff);
        queue_item(ima_pkg::OP_LOAD_B, 0, 0, 32'h7fff_ffff);
        queue_item(ima_pkg::OP_MULT, 0, 0, 32'd0);
        queue_item(ima_pkg::OP_LOAD_A, 0, 0, 32'h8000_0000);
        queue_item(ima_pkg::OP_MULT, 7, 7, 32'hffff_ffff);
        queue_item(ima_pkg::OP_LOAD_B, 0, 0, 32'h8000_0000);
        queue_item(ima_pkg::OP_MULT, 0, 0, 32'd0);
        queue_item(ima_pkg::OP_LOAD_A, 7, 7, 32'hffff_ffff);
        queue_item(ima_pkg::OP_LOAD_B, 7, 7, 32'h8000_0000);
        queue_item(ima_pkg::OP_LOAD_A, 0, 0, 32'hffff_ffff);
        queue_item(ima_pkg::OP_LOAD_B, 0, 0, 32'hffff_ffff);
        queue_item(ima_pkg::OP_MULT, 3, 5, 32'h5555_aaaa);
        queue_item(OP_NONE, 0, 0, 32'd0);

        // shape extremes, mismatch, and out-of-range dimension values
        run_phase(4'd8, 4'd1, 4'd1, 4'd8, 0, 2, 1'b1);
        run_phase(4'd1, 4'd8, 4'd8, 4'd1, 1, 2, 1'b0);
        run_phase(4'd2, 4'd3, 4'd2, 4'd3, 2, 2, 1'b0);
        run_phase(4'd0, 4'd15, 4'd8, 4'd0, 3, 2, 1'b0);
        run_phase(4'd15, 4'd1, 4'd0, 4'd9, 0, 1, 1'b0);
        run_phase(4'd4, 4'd5, 4'd3, 4'd2, 1, 2, 1'b0);

        // random shapes, mostly matching inner dimensions
        phase_no = 2;
        while (queued < ITEM_TARGET)
        begin
            ra = pick_dim();
            ca = pick_dim();
            rb = ($urandom_range(4) == 0) ? pick_dim() : ca;
            cb = pick_dim();
            run_phase(ra, ca, rb, cb, phase_no % 4, $urandom_range(4, 2), 1'b0);
            phase_no++;
        end
        wait_idle();

        $display("covered %0d input beats over %0d configurations",
                 items_in, phase_count);
        $display("%0d multiplies (%0d not possible), checked %0d result beats, %0d errors",
                 mult_runs, no_product_runs, beats_out, err_count);
        if (err_count == 0)
            $display("integer_matrix_multiply_tb OK");
        else
            $display("integer_matrix_multiply_tb NOT OK");
        $finish;
    end

    // watchdog
    initial
    begin
        #2_000_000;
        $display("integer_matrix_multiply_tb NOT OK");
        $finish;
    end

endmodule
